/* rtl/pidfp_pkg.sv */
package pidfp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SUM_WIDTH      = 48;
    localparam int WIDE           = 62;
    localparam int ACC_WIDTH      = WIDE + 2;
    localparam int PERIOD_WIDTH   = 16;
    localparam int PERIOD_FRAC    = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PER  = 3'd5;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST  = 16'd6554;
    localparam logic [PERIOD_WIDTH-1:0] INV_PER_RST = 16'd10;

    localparam int SHIFT_W = 2;
    localparam logic [SHIFT_W-1:0] SHIFT_NONE   = 2'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_PERIOD = 2'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_FRAC   = 2'd2;

    typedef struct packed {
        logic                start;
        logic [SHIFT_W-1:0]  shift;
    } t_mul_req;

endpackage

/* rtl/pidfp_regs.sv */
module pidfp_regs #(
    parameter int DATA_WIDTH = pidfp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidfp_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we,
    input  logic [pidfp_pkg::CFG_IDX_W-1:0]        i_index,
    input  logic [DATA_WIDTH-1:0]                  i_data,
    output logic signed [DATA_WIDTH-1:0]           o_gain_p,
    output logic signed [DATA_WIDTH-1:0]           o_gain_i,
    output logic signed [DATA_WIDTH-1:0]           o_gain_d,
    output logic signed [DATA_WIDTH-1:0]           o_setpoint,
    output logic [pidfp_pkg::PERIOD_WIDTH-1:0]     o_period,
    output logic [pidfp_pkg::PERIOD_WIDTH-1:0]     o_inv_period
);

    localparam logic [DATA_WIDTH-1:0] GAIN_P_RST = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_gain_p     <= GAIN_P_RST;
            o_gain_i     <= '0;
            o_gain_d     <= '0;
            o_setpoint   <= '0;
            o_period     <= pidfp_pkg::PERIOD_RST;
            o_inv_period <= pidfp_pkg::INV_PER_RST;
        end else if (i_we) begin
            unique case (i_index)
                pidfp_pkg::REG_GAIN_P: begin
                    o_gain_p <= i_data;
                end
                pidfp_pkg::REG_GAIN_I: begin
                    o_gain_i <= i_data;
                end
                pidfp_pkg::REG_GAIN_D: begin
                    o_gain_d <= i_data;
                end
                pidfp_pkg::REG_SETPOINT: begin
                    o_setpoint <= i_data;
                end
                pidfp_pkg::REG_PERIOD: begin
                    o_period <= i_data[pidfp_pkg::PERIOD_WIDTH-1:0];
                end
                pidfp_pkg::REG_INV_PER: begin
                    o_inv_period <= i_data[pidfp_pkg::PERIOD_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/pidfp_smul.sv */
module pidfp_smul #(
    parameter int MW        = pidfp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS = pidfp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pidfp_pkg::t_mul_req                 i_req,
    input  logic signed [pidfp_pkg::WIDE-1:0]   i_a,
    input  logic signed [MW-1:0]                i_b,
    output logic                                o_done,
    output logic signed [pidfp_pkg::WIDE-1:0]   o_res
);

    localparam int AW = pidfp_pkg::WIDE;
    localparam int PW = AW + 1 + MW;
    localparam int CW = $clog2(MW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic signed [AW-1:0] RES_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] RES_MIN = {1'b1, {(AW-1){1'b0}}};

    logic [1:0]                       r_state;
    logic signed [AW-1:0]             r_a;
    logic signed [AW:0]               r_hi;
    logic [MW-1:0]                    r_lo;
    logic [CW-1:0]                    r_cnt;
    logic [pidfp_pkg::SHIFT_W-1:0]    r_shift;

    logic                             last;
    logic signed [AW:0]               a_ext;
    logic signed [AW:0]               addend;
    logic signed [AW:0]               n_hi;
    logic signed [PW-1:0]             full;
    logic signed [PW-1:0]             shifted;
    logic                             in_range;
    logic signed [AW-1:0]             n_res;

    // The multiplier word enters one bit a cycle from the low end; its sign bit
    // carries negative weight, so the last step subtracts.
    always_comb begin
        last   = (r_cnt == CW'(MW - 1));
        a_ext  = (AW + 1)'(r_a);
        addend = '0;
        if (r_lo[0]) begin
            addend = last ? -a_ext : a_ext;
        end
        n_hi = r_hi + addend;

        full = {r_hi, r_lo};
        unique case (r_shift)
            pidfp_pkg::SHIFT_PERIOD: begin
                shifted = full >>> pidfp_pkg::PERIOD_FRAC;
            end
            pidfp_pkg::SHIFT_FRAC: begin
                shifted = full >>> FRAC_BITS;
            end
            default: begin
                shifted = full;
            end
        endcase
        in_range = (&shifted[PW-1:AW-1]) || !(|shifted[PW-1:AW-1]);
        if (in_range) begin
            n_res = shifted[AW-1:0];
        end else begin
            n_res = shifted[PW-1] ? RES_MIN : RES_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    o_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_a     <= i_a;
                r_hi    <= '0;
                r_lo    <= i_b;
                r_cnt   <= '0;
                r_shift <= i_req.shift;
            end
            ST_RUN: begin
                r_hi  <= {n_hi[AW], n_hi[AW:1]};
                r_lo  <= {n_hi[0], r_lo[MW-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_FIN: begin
                o_res <= n_res;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/pid_controller_fixed_period.sv */
// Channel   Direction  Handshake                 Word
// input     in         i_valid / o_stall         i_measurement
// output    out        o_valid / i_stall         o_drive
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The bit-serial multiplier, MW = max(DATA_WIDTH, 17) bits wide, runs five products in
// turn for each measurement.
// Synchronous active-low reset clears the integral and the previous error and returns the registers to their defaults.
// o_stall is high while a measurement is in work; a result held by i_stall does not stop
// the next measurement, but its result then waits in S_DONE with o_stall high.
module pid_controller_fixed_period #(
    parameter int DATA_WIDTH = pidfp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidfp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [DATA_WIDTH-1:0]      i_measurement,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_drive,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pidfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data
);

    localparam int MW  = (DATA_WIDTH > pidfp_pkg::PERIOD_WIDTH) ? DATA_WIDTH
                                                                : pidfp_pkg::PERIOD_WIDTH + 1;
    localparam int DW1 = DATA_WIDTH + 1;
    localparam int SW  = pidfp_pkg::SUM_WIDTH;
    localparam int SW1 = SW + 1;
    localparam int WD  = pidfp_pkg::WIDE;
    localparam int AC  = pidfp_pkg::ACC_WIDTH;

    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0]         S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]         S_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_INC  = 3'd2;
    localparam logic [2:0] S_DER  = 3'd3;
    localparam logic [2:0] S_TP   = 3'd4;
    localparam logic [2:0] S_TI   = 3'd5;
    localparam logic [2:0] S_TD   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic signed [DATA_WIDTH-1:0]           gain_p;
    logic signed [DATA_WIDTH-1:0]           gain_i;
    logic signed [DATA_WIDTH-1:0]           gain_d;
    logic signed [DATA_WIDTH-1:0]           setpoint;
    logic [pidfp_pkg::PERIOD_WIDTH-1:0]     period;
    logic [pidfp_pkg::PERIOD_WIDTH-1:0]     inv_period;

    logic [2:0]                             r_state;
    logic signed [DATA_WIDTH-1:0]           r_meas;
    logic signed [DATA_WIDTH-1:0]           r_err;
    logic signed [DATA_WIDTH-1:0]           r_last;
    logic signed [SW-1:0]                   r_sum;
    logic signed [WD-1:0]                   r_deriv;
    logic signed [AC-1:0]                   r_acc;
    logic                                   r_ovalid;
    logic signed [DATA_WIDTH-1:0]           r_drive;
    pidfp_pkg::t_mul_req                    r_req;
    logic signed [WD-1:0]                   r_mul_a;
    logic signed [MW-1:0]                   r_mul_b;

    logic                                   mul_done;
    logic signed [WD-1:0]                   mul_res;

    logic signed [DW1-1:0]                  err_diff;
    logic signed [DATA_WIDTH-1:0]           err_sat;
    logic signed [DW1-1:0]                  der_diff;
    logic signed [SW1-1:0]                  sum_wide;
    logic signed [SW-1:0]                   sum_sat;
    logic signed [AC-1:0]                   acc_next;
    logic signed [DATA_WIDTH-1:0]           drive_sat;
    logic                                   out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_drive     = r_drive;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_stall;

    pidfp_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (i_cfg_valid && o_cfg_ready),
        .i_index      (i_cfg_index),
        .i_data       (i_cfg_data),
        .o_gain_p     (gain_p),
        .o_gain_i     (gain_i),
        .o_gain_d     (gain_d),
        .o_setpoint   (setpoint),
        .o_period     (period),
        .o_inv_period (inv_period)
    );

    pidfp_smul #(
        .MW        (MW),
        .FRAC_BITS (FRAC_BITS)
    ) u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_comb begin
        err_diff = DW1'(setpoint) - DW1'(r_meas);
        if (err_diff[DW1-1] != err_diff[DW1-2]) begin
            err_sat = err_diff[DW1-1] ? D_MIN : D_MAX;
        end else begin
            err_sat = err_diff[DATA_WIDTH-1:0];
        end

        der_diff = DW1'(r_err) - DW1'(r_last);

        // The integral step is never wider than the error, so its low bits hold it whole.
        sum_wide = SW1'(r_sum) + SW1'(mul_res);
        if (sum_wide[SW1-1] != sum_wide[SW1-2]) begin
            sum_sat = sum_wide[SW1-1] ? S_MIN : S_MAX;
        end else begin
            sum_sat = sum_wide[SW-1:0];
        end

        acc_next = r_acc + AC'(mul_res);
        if ((&r_acc[AC-1:DATA_WIDTH-1]) || !(|r_acc[AC-1:DATA_WIDTH-1])) begin
            drive_sat = r_acc[DATA_WIDTH-1:0];
        end else begin
            drive_sat = r_acc[AC-1] ? D_MIN : D_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_req.start <= 1'b0;
            r_last      <= '0;
            r_sum       <= '0;
        end else begin
            r_req.start <= 1'b0;
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_req.start <= 1'b1;
                    r_req.shift <= pidfp_pkg::SHIFT_PERIOD;
                    r_state     <= S_INC;
                end
                S_INC: begin
                    if (mul_done) begin
                        r_sum       <= sum_sat;
                        r_last      <= r_err;
                        r_req.start <= 1'b1;
                        r_req.shift <= pidfp_pkg::SHIFT_NONE;
                        r_state     <= S_DER;
                    end
                end
                S_DER: begin
                    if (mul_done) begin
                        r_req.start <= 1'b1;
                        r_req.shift <= pidfp_pkg::SHIFT_FRAC;
                        r_state     <= S_TP;
                    end
                end
                S_TP: begin
                    if (mul_done) begin
                        r_req.start <= 1'b1;
                        r_state     <= S_TI;
                    end
                end
                S_TI: begin
                    if (mul_done) begin
                        r_req.start <= 1'b1;
                        r_state     <= S_TD;
                    end
                end
                S_TD: begin
                    if (mul_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_ovalid && !i_stall) begin
                        r_ovalid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_meas <= i_measurement;
            end
            S_ERR: begin
                r_err   <= err_sat;
                r_mul_a <= WD'(err_sat);
                r_mul_b <= MW'(period);
            end
            S_INC: begin
                r_mul_a <= WD'(der_diff);
                r_mul_b <= MW'(inv_period);
            end
            S_DER: begin
                r_deriv <= mul_res;
                r_mul_a <= WD'(r_err);
                r_mul_b <= MW'(gain_p);
            end
            S_TP: begin
                r_acc   <= AC'(mul_res);
                r_mul_a <= WD'(r_sum);
                r_mul_b <= MW'(gain_i);
            end
            S_TI: begin
                if (mul_done) begin
                    r_acc <= acc_next;
                end
                r_mul_a <= r_deriv;
                r_mul_b <= MW'(gain_d);
            end
            S_TD: begin
                if (mul_done) begin
                    r_acc <= acc_next;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_drive <= drive_sat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* tb/pid_controller_fixed_period_test.sv */
`timescale 1ns / 100ps

module pid_controller_fixed_period_test;

    localparam int DW = pidfp_pkg::DATA_WIDTH_DEF;
    localparam int FB = pidfp_pkg::FRAC_BITS_DEF;
    localparam int IW = pidfp_pkg::CFG_IDX_W;
    localparam int PW = pidfp_pkg::PERIOD_WIDTH;
    localparam int SW = pidfp_pkg::SUM_WIDTH;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [DW-1:0] i_measurement = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [DW-1:0] o_drive;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IW-1:0]        i_cfg_index = '0;
    logic [DW-1:0]        i_cfg_data = '0;

    // Controller state as the block should hold it.
    logic signed [DW-1:0] gain_p;
    logic signed [DW-1:0] gain_i;
    logic signed [DW-1:0] gain_d;
    logic signed [DW-1:0] target;
    logic [PW-1:0]        step_q16;
    logic [PW-1:0]        step_inverse;
    logic signed [SW-1:0] integral;
    logic signed [DW-1:0] prev_error;

    logic signed [DW-1:0] expected_drive[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit idling_on = 1'b1;
    int hold_request = 0;
    int stall_left = 0;

    pid_controller_fixed_period dut (
        .i_clk         (clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic signed [127:0] clamp(input logic signed [127:0] v, input int w);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (w - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [127:0] scaled_product(input logic signed [127:0] a,
                                                           input logic signed [127:0] b,
                                                           input int s);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> s;
        return clamp(p, pidfp_pkg::WIDE);
    endfunction

    function automatic logic signed [DW-1:0] next_drive(input logic signed [DW-1:0] meas);
        logic signed [127:0] sp, m, per, inv, acc, err, inc, diff, deriv;
        logic signed [127:0] gp, gi, gd, tp, ti, td, total;
        sp = target;
        m = meas;
        per = step_q16;
        inv = step_inverse;
        gp = gain_p;
        gi = gain_i;
        gd = gain_d;
        err = clamp(sp - m, DW);
        inc = scaled_product(err, per, pidfp_pkg::PERIOD_FRAC);
        acc = integral;
        acc = clamp(clamp(acc + inc, pidfp_pkg::WIDE), SW);
        diff = prev_error;
        diff = err - diff;
        deriv = scaled_product(diff, inv, 0);
        tp = scaled_product(gp, err, FB);
        ti = scaled_product(gi, acc, FB);
        td = scaled_product(gd, deriv, FB);
        total = clamp(tp + ti + td, DW);
        integral = acc[SW-1:0];
        prev_error = err[DW-1:0];
        return total[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] random_gain();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    function automatic logic [DW-1:0] random_measurement();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return target + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    task automatic send_measurement(input logic signed [DW-1:0] value);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        i_valid = 1'b1;
        i_measurement = value;
        forever begin
            @(posedge clk);
            if (!o_stall) break;
        end
        expected_drive.push_back(next_drive(value));
    endtask

    task automatic quiesce();
        @(negedge clk);
        i_valid = 1'b0;
        while (expected_drive.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [IW-1:0] index,
                                  input logic [DW-1:0] data);
        @(negedge clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        forever begin
            @(posedge clk);
            if (o_cfg_ready) break;
        end
        case (index)
            pidfp_pkg::REG_GAIN_P:   gain_p = data;
            pidfp_pkg::REG_GAIN_I:   gain_i = data;
            pidfp_pkg::REG_GAIN_D:   gain_d = data;
            pidfp_pkg::REG_SETPOINT: target = data;
            pidfp_pkg::REG_PERIOD:   step_q16 = data[PW-1:0];
            pidfp_pkg::REG_INV_PER:  step_inverse = data[PW-1:0];
            default: ;
        endcase
        @(negedge clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_values();
        send_measurement(32'sh0000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(-32'sd1);
        send_measurement(32'sd1);
        send_measurement(32'sh0001_0000);
    endtask

    task automatic test_saturation();
        quiesce();
        write_register(pidfp_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
        write_register(pidfp_pkg::REG_GAIN_I, 32'h7FFF_FFFF);
        write_register(pidfp_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
        write_register(pidfp_pkg::REG_SETPOINT, 32'h8000_0000);
        write_register(pidfp_pkg::REG_PERIOD, 32'hFFFF_FFFF);
        write_register(pidfp_pkg::REG_INV_PER, 32'hFFFF_FFFF);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        quiesce();
        write_register(pidfp_pkg::REG_GAIN_P, 32'h8000_0000);
        write_register(pidfp_pkg::REG_GAIN_I, 32'h8000_0000);
        write_register(pidfp_pkg::REG_GAIN_D, 32'h8000_0000);
        write_register(pidfp_pkg::REG_SETPOINT, 32'h7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
    endtask

    task automatic test_zero_period();
        quiesce();
        write_register(pidfp_pkg::REG_GAIN_P, 32'h0001_0000);
        write_register(pidfp_pkg::REG_GAIN_I, 32'h0000_8000);
        write_register(pidfp_pkg::REG_GAIN_D, 32'h0002_0000);
        write_register(pidfp_pkg::REG_SETPOINT, 32'h0000_0000);
        write_register(pidfp_pkg::REG_PERIOD, 32'h5A5A_0000);
        write_register(pidfp_pkg::REG_INV_PER, 32'hABCD_0000);
        repeat (3) send_measurement(random_measurement());
    endtask

    task automatic test_unknown_register();
        quiesce();
        write_register(REG_SPARE_LO, $urandom);
        write_register(REG_SPARE_HI, $urandom);
        repeat (3) send_measurement(random_measurement());
    endtask

    task automatic random_settings();
        logic [DW-1:0] data;
        quiesce();
        write_register(pidfp_pkg::REG_GAIN_P, random_gain());
        write_register(pidfp_pkg::REG_GAIN_I, random_gain());
        write_register(pidfp_pkg::REG_GAIN_D, random_gain());
        if ($urandom_range(0, 1) == 0) begin
            write_register(pidfp_pkg::REG_SETPOINT, $urandom);
        end else begin
            write_register(pidfp_pkg::REG_SETPOINT,
                           int'($urandom_range(0, 1 << 24)) - (1 << 23));
        end
        data = $urandom;
        if ($urandom_range(0, 7) == 0) data[PW-1:0] = '1;
        write_register(pidfp_pkg::REG_PERIOD, data);
        data = $urandom;
        if ($urandom_range(0, 7) == 0) data[PW-1:0] = '0;
        write_register(pidfp_pkg::REG_INV_PER, data);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 12; phase++) begin
            idling_on = (phase % 3 != 2);
            random_settings();
            repeat (150) send_measurement(random_measurement());
        end
    endtask

    task automatic test_backpressure();
        idling_on = 1'b1;
        random_settings();
        hold_request = HOLD_CYCLES;
        repeat (12) send_measurement(random_measurement());
    endtask

    task automatic test_steady_stream();
        idling_on = 1'b0;
        random_settings();
        repeat (150) send_measurement(random_measurement());
    endtask

    // The receiver stalls in bursts, or for one long hold when asked.
    always @(negedge clk) begin
        if (hold_request != 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if (stall_left != 0) begin
            i_stall = 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    always @(posedge clk) begin : check_drive
        logic signed [DW-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_drive.size() == 0) begin
                $error("drive: expected none, actual %0d", o_drive);
                mismatches++;
            end else begin
                want = expected_drive.pop_front();
                if (o_drive !== want) begin
                    $error("drive: expected %0d, actual %0d", want, o_drive);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        gain_p = 32'sd1 <<< FB;
        gain_i = '0;
        gain_d = '0;
        target = '0;
        step_q16 = pidfp_pkg::PERIOD_RST;
        step_inverse = pidfp_pkg::INV_PER_RST;
        integral = '0;
        prev_error = '0;
        repeat (12) @(negedge clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_saturation();
        test_zero_period();
        test_unknown_register();
        test_random_phases();
        test_backpressure();
        test_steady_stream();

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
